@@ src/y2r_pkg.sv @@
// shared types, constants and helpers for the yuyv to rgba converter
// no dependencies
package y2r_pkg;

  localparam int ROW_PIXELS_W = 13;
  localparam int ROW_COUNT_W  = 13;
  localparam int LINE_BYTES_W = 15;
  localparam int CFG_W        = 15;
  localparam int CFG_INDEX_W  = 2;
  localparam int PAD_W        = 14;

  localparam int DEF_MAX_ROW_PIXELS = 4096;
  localparam int DEF_MAX_ROWS       = 4096;

  localparam logic [ROW_PIXELS_W-1:0] RESET_ROW_PIXELS = 13'd160;
  localparam logic [ROW_COUNT_W-1:0]  RESET_ROW_COUNT  = 13'd120;
  localparam logic [LINE_BYTES_W-1:0] RESET_LINE_BYTES = 15'd320;

  localparam logic [PAD_W-1:0] PAD_LIMIT    = 14'h3FFF;
  localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

  // depth of the group queue between front and back
  localparam int Q_DEPTH = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_PIXELS = 2'd0,
    REG_ROW_COUNT  = 2'd1,
    REG_LINE_BYTES = 2'd2
  } cfg_reg_t;

  // one complete yuyv group as handed from front to back
  typedef struct packed {
    logic [7:0] y0;
    logic [7:0] u;
    logic [7:0] y1;
    logic [7:0] v;
    logic       frame_last;
  } group_t;

  function automatic logic [7:0] clip8(input logic signed [10:0] c);
    logic [7:0] r;
    if (c > 11'sd255) begin
      r = 8'hFF;
    end else if (c < 11'sd0) begin
      r = 8'h00;
    end else begin
      r = c[7:0];
    end
    return r;
  endfunction

endpackage

@@ src/y2r_front.sv @@
// front end: takes stream bytes, skips row padding, collects yuyv groups
// depends on y2r_pkg
module y2r_front #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int MAX_ROWS       = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic [7:0]                          data_byte,
  input  logic [y2r_pkg::ROW_PIXELS_W-1:0]    row_pixels,
  input  logic [y2r_pkg::ROW_COUNT_W-1:0]     row_count,
  input  logic [y2r_pkg::LINE_BYTES_W-1:0]    line_bytes,
  output logic                                push,
  output y2r_pkg::group_t                     group
);
  import y2r_pkg::*;

  localparam int COL_W = $clog2(MAX_ROW_PIXELS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam logic [14:0] MAX_W15 = 15'(MAX_ROW_PIXELS) & ~15'd1;
  localparam logic [14:0] MAX_R15 = 15'(MAX_ROWS);

  logic [1:0]       phase;
  logic [7:0]       y0;
  logic [7:0]       u;
  logic [7:0]       y1;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [PAD_W-1:0] pad_left;

  logic [14:0]      width_even;
  logic [14:0]      eff_w;
  logic [14:0]      rows15;
  logic [14:0]      eff_r;
  logic [15:0]      need;
  logic [15:0]      line16;
  logic [15:0]      diff;
  logic [PAD_W-1:0] pad;
  logic             row_end;
  logic             row_wrap;
  logic [ROW_W-1:0] row_step;

  // effective geometry from the live registers
  always_comb begin
    width_even = {2'b00, row_pixels[ROW_PIXELS_W-1:1], 1'b0};
    if (width_even == 15'd0) begin
      eff_w = 15'd2;
    end else if (width_even > MAX_W15) begin
      eff_w = MAX_W15;
    end else begin
      eff_w = width_even;
    end
    rows15 = 15'(row_count);
    if (rows15 == 15'd0) begin
      eff_r = 15'd1;
    end else if (rows15 > MAX_R15) begin
      eff_r = MAX_R15;
    end else begin
      eff_r = rows15;
    end
    need   = {eff_w, 1'b0};
    line16 = 16'(line_bytes);
    diff   = line16 - need;
    if (line16 <= need) begin
      pad = '0;
    end else if (diff > 16'(PAD_LIMIT)) begin
      pad = PAD_LIMIT;
    end else begin
      pad = diff[PAD_W-1:0];
    end
    row_end  = (16'(col) + 16'd2) >= 16'(eff_w);
    row_wrap = (16'(row) + 16'd1) >= 16'(eff_r);
    row_step = row_wrap ? '0 : row + ROW_W'(1);
  end

  assign push = accept && (pad_left == '0) && (phase == 2'd3);
  assign group = '{y0: y0, u: u, y1: y1, v: data_byte, frame_last: row_end && row_wrap};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 2'd0;
      col      <= '0;
      row      <= '0;
      pad_left <= '0;
    end else if (accept) begin
      if (pad_left != '0) begin
        pad_left <= pad_left - PAD_W'(1);
        if (pad_left == PAD_W'(1)) begin
          row <= row_step;
        end
      end else begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          if (row_end) begin
            col <= '0;
            if (pad != '0) begin
              pad_left <= pad;
            end else begin
              row <= row_step;
            end
          end else begin
            col <= col + COL_W'(2);
          end
        end
      end
    end
  end

  // held group bytes
  always_ff @(posedge clk) begin
    if (accept && (pad_left == '0)) begin
      unique case (phase)
        2'd0: y0 <= data_byte;
        2'd1: u  <= data_byte;
        2'd2: y1 <= data_byte;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ src/y2r_queue.sv @@
// short group queue between front and back
// depends on y2r_pkg
module y2r_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  y2r_pkg::group_t wr_data,
  input  logic            pop,
  output y2r_pkg::group_t rd_data,
  output logic            full,
  output logic            avail
);
  import y2r_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  group_t           slots [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(Q_DEPTH));
  assign avail   = (count != '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ src/y2r_back.sv @@
// back end: chroma terms, then two clipped rgb pixels per group
// depends on y2r_pkg
module y2r_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_avail,
  input  y2r_pkg::group_t q_data,
  output logic            q_pop,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic            pair_last,
  output logic            frame_last
);
  import y2r_pkg::*;

  logic               a_valid;
  logic [7:0]         a_y0;
  logic [7:0]         a_y1;
  logic               a_fl;
  logic signed [9:0]  a_r;
  logic signed [9:0]  a_g;
  logic signed [9:0]  a_b;
  logic               sel;

  logic               out_load;
  logic               a_take;
  logic               a_free;

  logic signed [7:0]  u_s;
  logic signed [7:0]  v_s;
  logic signed [15:0] u16;
  logic signed [11:0] u12;
  logic signed [11:0] v12;
  logic signed [10:0] v11;
  logic signed [15:0] bsum;
  logic signed [11:0] gsum;
  logic signed [10:0] rsum;

  logic [7:0]         y_sel;
  logic signed [10:0] y11;
  logic signed [10:0] r_sum;
  logic signed [10:0] g_sum;
  logic signed [10:0] b_sum;

  assign out_load = !out_valid || !out_stall;
  assign a_take   = out_load && a_valid && sel;
  assign a_free   = !a_valid || a_take;
  assign q_pop    = q_avail && a_free;

  // offset removal by flipping the top bit, then shift-and-add terms
  always_comb begin
    u_s  = $signed({~q_data.u[7], q_data.u[6:0]});
    v_s  = $signed({~q_data.v[7], q_data.v[6:0]});
    u16  = 16'(u_s);
    u12  = 12'(u_s);
    v12  = 12'(v_s);
    v11  = 11'(v_s);
    bsum = (u16 <<< 7) + u16;
    gsum = u12 + (u12 <<< 1) + (v12 <<< 1) + (v12 <<< 2);
    rsum = v11 + (v11 <<< 1);
  end

  always_comb begin
    y_sel = sel ? a_y1 : a_y0;
    y11   = $signed({3'b000, y_sel});
    r_sum = y11 + 11'(a_r);
    g_sum = y11 - 11'(a_g);
    b_sum = y11 + 11'(a_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= q_avail;
      end
      if (out_load) begin
        out_valid <= a_valid;
        if (a_valid) begin
          sel <= ~sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_y0 <= q_data.y0;
      a_y1 <= q_data.y1;
      a_fl <= q_data.frame_last;
      a_b  <= bsum[15:6];
      a_g  <= {gsum[11], gsum[11:3]};
      a_r  <= rsum[10:1];
    end
    if (out_load && a_valid) begin
      red        <= clip8(r_sum);
      green      <= clip8(g_sum);
      blue       <= clip8(b_sum);
      pair_last  <= sel;
      frame_last <= sel && a_fl;
    end
  end

endmodule

@@ src/yuyv_stream_to_rgba.sv @@
// yuyv 4:2:2 byte stream to rgba pixel converter, top level
// depends on y2r_pkg, y2r_front, y2r_queue, y2r_back
// throughput: one byte a cycle unless the queue is full, two pixels for
//   every four pixel bytes; a group passes the queue, the chroma term
//   stage and output register; the second pixel follows when not stalled
// reset: clears phase, position, padding, queue and output state, restores the
//   geometry registers to 160 pixels, 120 rows and 320 bytes per line
module yuyv_stream_to_rgba #(
  parameter int MAX_ROW_PIXELS = y2r_pkg::DEF_MAX_ROW_PIXELS,
  parameter int MAX_ROWS       = y2r_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_write,
  input  logic [y2r_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [y2r_pkg::CFG_W-1:0]       cfg_data,
  // byte input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  // pixel output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue,
  output logic [7:0]                      alpha,
  output logic                            pair_last,
  output logic                            frame_last
);
  import y2r_pkg::*;

  // geometry registers
  logic [ROW_PIXELS_W-1:0] row_pixels;
  logic [ROW_COUNT_W-1:0]  row_count;
  logic [LINE_BYTES_W-1:0] line_bytes;

  // front to queue to back
  logic   in_accept;
  logic   q_push;
  group_t q_wr;
  group_t q_rd;
  logic   q_pop;
  logic   q_full;
  logic   q_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pixels <= RESET_ROW_PIXELS;
      row_count  <= RESET_ROW_COUNT;
      line_bytes <= RESET_LINE_BYTES;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_PIXELS: row_pixels <= cfg_data[ROW_PIXELS_W-1:0];
        REG_ROW_COUNT:  row_count  <= cfg_data[ROW_COUNT_W-1:0];
        REG_LINE_BYTES: line_bytes <= cfg_data[LINE_BYTES_W-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // the front only holds off while the group queue is full; padding and
  // the first three bytes of a group never need room but are held too
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  y2r_front #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
    .MAX_ROWS       (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .data_byte  (data_byte),
    .row_pixels (row_pixels),
    .row_count  (row_count),
    .line_bytes (line_bytes),
    .push       (q_push),
    .group      (q_wr)
  );

  // lets the byte side run on while the pixel side is stalled
  y2r_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .avail   (q_avail)
  );

  // chroma term stage, then output register giving both pixels in turn
  y2r_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_avail    (q_avail),
    .q_data     (q_rd),
    .q_pop      (q_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .pair_last  (pair_last),
    .frame_last (frame_last)
  );

  // alpha is fixed opaque
  assign alpha = ALPHA_OPAQUE;

`ifndef ASSERT_OFF
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("group pushed into a full queue");

  a_pop_avail: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_avail)
    else $error("group popped from an empty queue");

  a_frame_on_second: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_last) |-> pair_last)
    else $error("frame end flagged on first pixel of a pair");
`endif

endmodule
